>>> rtl/cptg_pkg.sv
// cptg_pkg: types, constants and rate tables of the cip packet timing generator
// no dependencies; used by cptg_step, cip_packet_timing_generator, cptg_checker and testbench

package cptg_pkg;

  // input word codes
  localparam logic ModeStart = 1'b0;
  localparam logic ModeTick  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CfgRateCode      = 3'd0;
  localparam logic [2:0] CfgBlockingMode  = 3'd1;
  localparam logic [2:0] CfgAltPattern    = 3'd2;
  localparam logic [2:0] CfgSourceNode    = 3'd3;
  localparam logic [2:0] CfgBlockQuadlets = 3'd4;
  localparam logic [2:0] CfgPresentDelay  = 3'd5;

  // rate codes with special handling
  localparam logic [2:0] Rate441k  = 3'd1;
  localparam logic [2:0] Rate96k   = 3'd4;
  localparam logic [2:0] Rate192k  = 3'd6;
  localparam logic [2:0] RateAlias = 3'd7;

  localparam logic [12:0] TicksPerCycle = 13'd3072;
  localparam logic [15:0] SytNoInfo     = 16'hffff;
  localparam logic [6:0]  MaxBlocks     = 7'd32;
  localparam logic [7:0]  PhaseLen441   = 8'd80;
  localparam logic [12:0] SytPhaseLen   = 13'd147;
  localparam logic [11:0] SytPhaseLast  = 12'd146;
  localparam logic [10:0] SytStep441    = 11'd1386;
  localparam logic [3:0]  SytCycleLen   = 4'd13;
  localparam logic [4:0]  AltPhaseLen   = 5'd16;
  localparam logic [6:0]  AltHighLimit  = 7'd7;
  localparam logic [6:0]  AltBlocksLow  = 7'd7;
  localparam logic [6:0]  AltBlocksHigh = 7'd5;
  localparam logic [6:0]  BlocksPer441  = 7'd11;
  localparam logic [6:0]  Phase441Flip  = 7'd40;
  localparam logic [7:0]  CipFmtAm824   = 8'h90;  // eoh bit and fmt field of quadlet one

  typedef struct packed {
    logic [2:0]  rate_code;
    logic        blocking_mode;
    logic        alt_pattern_mode;
    logic [5:0]  source_node;
    logic [7:0]  block_quadlets;
    logic [14:0] present_delay;
  } cfg_t;

  // syt_idx tracks syt_phase mod 13
  typedef struct packed {
    logic [6:0]  block_phase;
    logic [11:0] syt_phase;
    logic [3:0]  syt_idx;
    logic [12:0] last_offset;
    logic [7:0]  block_counter;
  } state_t;

  typedef struct packed {
    logic [5:0]  pkt_blocks;
    logic [15:0] syt;
    logic [7:0]  block_count_field;
    logic [31:0] header_word0;
    logic [31:0] header_word1;
    logic [14:0] payload_bytes;
  } pkt_t;

  function automatic logic [6:0] init_blocks(input logic [2:0] r);
    case (r)
      3'd0:    init_blocks = 7'd4;
      3'd2:    init_blocks = 7'd6;
      3'd4:    init_blocks = 7'd12;
      3'd6:    init_blocks = 7'd24;
      3'd7:    init_blocks = 7'd24;
      default: init_blocks = 7'd0;
    endcase
  endfunction

  function automatic logic [11:0] init_syt(input logic [2:0] r);
    case (r)
      3'd0:    init_syt = 12'd3072;
      3'd2:    init_syt = 12'd1024;
      3'd4:    init_syt = 12'd1024;
      3'd6:    init_syt = 12'd1024;
      3'd7:    init_syt = 12'd1024;
      default: init_syt = 12'd67;
    endcase
  endfunction

  // start phase mod 13: 3072 -> 4, 1024 -> 10, 67 -> 2
  function automatic logic [3:0] init_syt_idx(input logic [2:0] r);
    case (r)
      3'd0:                   init_syt_idx = 4'd4;
      3'd2, 3'd4, 3'd6, 3'd7: init_syt_idx = 4'd10;
      default:                init_syt_idx = 4'd2;
    endcase
  endfunction

  function automatic logic [5:0] syt_span(input logic [2:0] r);
    case (r)
      3'd0, 3'd1, 3'd2: syt_span = 6'd8;
      3'd3, 3'd4:       syt_span = 6'd16;
      default:          syt_span = 6'd32;
    endcase
  endfunction

  localparam cfg_t CfgReset = '{
    rate_code:        3'd2,
    blocking_mode:    1'b0,
    alt_pattern_mode: 1'b0,
    source_node:      6'd0,
    block_quadlets:   8'd2,
    present_delay:    15'd8704
  };

  localparam state_t StateReset = '{
    block_phase:   7'd6,
    syt_phase:     12'd1024,
    syt_idx:       4'd10,
    last_offset:   13'd3072,
    block_counter: 8'd0
  };

endpackage

>>> rtl/cip_packet_timing_generator.sv
// cip_packet_timing_generator: an accepted word passes the input register, then the
// result register; throughput one word per cycle unless the result channel stalls
// the stream state updates through the combinational cptg_step, which sets the rate
// a start word updates state and yields no result word
// reset loads the register defaults and the stream state of a start at 48k
// depends on cptg_pkg and cptg_step

module cip_packet_timing_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [12:0] cycle_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pkt_blocks_o,
  output logic [15:0] syt_o,
  output logic [7:0]  block_count_field_o,
  output logic [31:0] header_word0_o,
  output logic [31:0] header_word1_o,
  output logic [14:0] payload_bytes_o
);

  cptg_pkg::cfg_t   cfg_q, cfg_d;
  cptg_pkg::state_t state_q, state_d;
  cptg_pkg::pkt_t   pkt_q, pkt_d;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_mode_q;
  logic [12:0] s1_cycle_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        s1_go;
  logic        in_take;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cptg_pkg::CfgRateCode:      cfg_d.rate_code        = cfg_data_i[2:0];
        cptg_pkg::CfgBlockingMode:  cfg_d.blocking_mode    = cfg_data_i[0];
        cptg_pkg::CfgAltPattern:    cfg_d.alt_pattern_mode = cfg_data_i[0];
        cptg_pkg::CfgSourceNode:    cfg_d.source_node      = cfg_data_i[5:0];
        cptg_pkg::CfgBlockQuadlets: cfg_d.block_quadlets   = cfg_data_i[7:0];
        cptg_pkg::CfgPresentDelay:  cfg_d.present_delay    = cfg_data_i;
        default:                    cfg_d = cfg_q;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cptg_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // handshake: a start word leaves stage one without needing the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && ((s1_mode_q == cptg_pkg::ModeStart) || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_take    = in_valid_i && in_ready_o;

  assign s1_valid_d = in_take || (s1_valid_q && !s1_go);

  // stream state and packet fields for the word in stage one
  cptg_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .mode_i  (s1_mode_q),
    .cycle_i (s1_cycle_q),
    .state_o (state_d),
    .pkt_o   (pkt_d)
  );

  // result register: loads on a tick leaving stage one, clears when taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_go && (s1_mode_q == cptg_pkg::ModeTick)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= cptg_pkg::StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q  <= mode_i;
      s1_cycle_q <= cycle_i;
    end
    if (s1_go && (s1_mode_q == cptg_pkg::ModeTick)) begin
      pkt_q <= pkt_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pkt_blocks_o        = pkt_q.pkt_blocks;
  assign syt_o               = pkt_q.syt;
  assign block_count_field_o = pkt_q.block_count_field;
  assign header_word0_o      = pkt_q.header_word0;
  assign header_word1_o      = pkt_q.header_word1;
  assign payload_bytes_o     = pkt_q.payload_bytes;

  // a tick leaving stage one always shows up as a result word
  a_tick_makes_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_mode_q == cptg_pkg::ModeTick)) |=> out_valid_q)
    else $error("tick word lost between stage one and result register");

  // block count never exceeds the saturation limit
  a_blocks_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, pkt_q.pkt_blocks} <= cptg_pkg::MaxBlocks))
    else $error("data block count above limit");

  // a start word reloads offset and counter
  a_start_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_mode_q == cptg_pkg::ModeStart)) |=>
      ((state_q.last_offset == cptg_pkg::TicksPerCycle) && (state_q.block_counter == 8'd0)))
    else $error("start word did not reload stream state");

endmodule

>>> rtl/cptg_step.sv
// cptg_step: next state and packet description for one start or cycle tick word
// depends on cptg_pkg

module cptg_step (
  input  cptg_pkg::cfg_t   cfg_i,
  input  cptg_pkg::state_t state_i,
  input  logic             mode_i,
  input  logic [12:0]      cycle_i,
  output cptg_pkg::state_t state_o,
  output cptg_pkg::pkt_t   pkt_o
);

  logic [2:0]  rate;
  logic [1:0]  half;
  logic        below;
  logic [3:0]  idx13;
  logic [3:0]  syt_idx_inc;
  logic [3:0]  syt_idx_odd;
  logic        syt_inc;
  logic [12:0] syt_ph_inc;
  logic [11:0] syt_phase_odd;
  logic [13:0] off;
  logic [12:0] new_off;
  logic        has_syt;
  logic [15:0] t_sum;
  logic [11:0] q3_prod;
  logic [4:0]  q_cyc;
  logic [15:0] t_rem;
  logic [15:0] syt;
  logic [6:0]  bp;
  logic [6:0]  alt_ph;
  logic [6:0]  alt_ph_inc;
  logic [7:0]  bp_inc;
  logic [7:0]  bp_limit;
  logic [6:0]  n_blocks;
  logic [6:0]  bp_next;
  logic [5:0]  blocks;
  logic [13:0] bq_prod;
  logic [15:0] payload;

  assign rate  = (cfg_i.rate_code == cptg_pkg::RateAlias) ? cptg_pkg::Rate192k : cfg_i.rate_code;
  assign half  = rate[2:1];
  assign below = state_i.last_offset < cptg_pkg::TicksPerCycle;

  // phase mod 13 comes from the state and steps with the phase
  assign idx13       = state_i.syt_idx;
  assign syt_inc     = ((idx13 != 4'd0) && (idx13[1:0] == 2'd0)) ||
                       (state_i.syt_phase == cptg_pkg::SytPhaseLast);
  assign syt_ph_inc    = {1'b0, state_i.syt_phase} + 13'd1;
  assign syt_phase_odd = (syt_ph_inc >= cptg_pkg::SytPhaseLen) ? 12'd0 : syt_ph_inc[11:0];
  assign syt_idx_inc   = (idx13 == cptg_pkg::SytCycleLen - 4'd1) ? 4'd0 : idx13 + 4'd1;
  assign syt_idx_odd   = (syt_ph_inc >= cptg_pkg::SytPhaseLen) ? 4'd0 : syt_idx_inc;

  always_comb begin
    if (!below) begin
      off = {1'b0, state_i.last_offset - cptg_pkg::TicksPerCycle};
    end else if (!rate[0]) begin
      off = {1'b0, state_i.last_offset} + {2'b0, state_i.syt_phase};
    end else begin
      off = {1'b0, state_i.last_offset} + {3'b0, cptg_pkg::SytStep441} + {13'd0, syt_inc};
    end
  end

  assign new_off = off[12:0];
  assign has_syt = new_off < cptg_pkg::TicksPerCycle;

  // split offset plus delay into whole cycles and ticks (3072 = 3 * 1024)
  assign t_sum   = {3'b0, new_off} + {1'b0, cfg_i.present_delay};
  assign q3_prod = {6'd0, t_sum[15:10]} * 12'd43;
  assign q_cyc   = q3_prod[11:7];
  assign t_rem   = t_sum - ({11'd0, q_cyc} * {3'd0, cptg_pkg::TicksPerCycle});
  assign syt     = has_syt ? {cycle_i[3:0] + q_cyc[3:0], t_rem[11:0]} : cptg_pkg::SytNoInfo;

  // data block count and phase
  assign bp         = state_i.block_phase;
  assign alt_ph     = (bp >= 7'(cptg_pkg::AltPhaseLen)) ? 7'd0 : bp;
  assign alt_ph_inc = (alt_ph + 7'd1 == 7'(cptg_pkg::AltPhaseLen)) ? 7'd0 : alt_ph + 7'd1;
  assign bp_inc     = {1'b0, bp} + 8'd1;
  assign bp_limit   = cptg_pkg::PhaseLen441 >> half;

  always_comb begin
    n_blocks = bp;
    bp_next  = bp;
    if (cfg_i.blocking_mode) begin
      n_blocks = has_syt ? {1'b0, cptg_pkg::syt_span(rate)} : 7'd0;
    end else if (!rate[0]) begin
      if (cfg_i.alt_pattern_mode && (rate != cptg_pkg::Rate96k)) begin
        n_blocks = (alt_ph > cptg_pkg::AltHighLimit) ? cptg_pkg::AltBlocksHigh
                                                     : cptg_pkg::AltBlocksLow;
        bp_next  = alt_ph_inc;
      end
    end else begin
      if (rate == cptg_pkg::Rate441k) begin
        n_blocks = 7'd5 + {6'd0, bp[0] ^ ((bp == 7'd0) || (bp >= cptg_pkg::Phase441Flip))};
      end else begin
        n_blocks = 7'(cptg_pkg::BlocksPer441 * {5'd0, half}) + {6'd0, bp == 7'd0};
      end
      bp_next = (bp_inc >= bp_limit) ? 7'd0 : bp_inc[6:0];
    end
  end

  assign blocks  = (n_blocks > cptg_pkg::MaxBlocks) ? 6'(cptg_pkg::MaxBlocks) : n_blocks[5:0];
  assign bq_prod = {8'd0, blocks} * {6'd0, cfg_i.block_quadlets};
  assign payload = 16'd8 + {bq_prod, 2'b00};

  always_comb begin
    if (mode_i == cptg_pkg::ModeStart) begin
      state_o.block_phase   = cfg_i.alt_pattern_mode ? 7'd0 : cptg_pkg::init_blocks(rate);
      state_o.syt_phase     = cptg_pkg::init_syt(rate);
      state_o.syt_idx       = cptg_pkg::init_syt_idx(rate);
      state_o.last_offset   = cptg_pkg::TicksPerCycle;
      state_o.block_counter = 8'd0;
    end else begin
      state_o.block_phase   = bp_next;
      state_o.syt_phase     = (below && rate[0]) ? syt_phase_odd : state_i.syt_phase;
      state_o.syt_idx       = (below && rate[0]) ? syt_idx_odd : state_i.syt_idx;
      state_o.last_offset   = new_off;
      state_o.block_counter = state_i.block_counter + {2'b0, blocks};
    end
  end

  always_comb begin
    pkt_o.pkt_blocks        = blocks;
    pkt_o.syt               = syt;
    pkt_o.block_count_field = state_i.block_counter;
    pkt_o.header_word0      = {2'b00, cfg_i.alt_pattern_mode ? 6'd0 : cfg_i.source_node,
                               cfg_i.block_quadlets, 8'd0, state_i.block_counter};
    pkt_o.header_word1      = {cptg_pkg::CipFmtAm824, 5'd0, rate,
                               cfg_i.alt_pattern_mode ? 16'd0 : syt};
    pkt_o.payload_bytes     = payload[14:0];
  end

endmodule

>>> tb/sv/cptg_checker.sv
// cptg_checker: predicts the result words of the cip packet timing generator and compares them
// watches the config, input and result channels; depends on cptg_pkg

module cptg_checker
  import cptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [12:0] cycle_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  pkt_blocks_i,
  input  logic [15:0] syt_i,
  input  logic [7:0]  block_count_field_i,
  input  logic [31:0] header_word0_i,
  input  logic [31:0] header_word1_i,
  input  logic [14:0] payload_bytes_i,
  output int          mismatches_o,
  output int          waiting_o
);

  // per-rate start values and blocking-mode packet sizes
  int unsigned start_blocks [7]   = '{4, 0, 6, 0, 12, 0, 24};
  int unsigned start_syt_step [7] = '{3072, 67, 1024, 67, 1024, 67, 1024};
  int unsigned syt_span_tab [7]   = '{8, 8, 8, 16, 16, 32, 32};

  cfg_t   regs;
  state_t stream;
  pkt_t   pending_packets [$];
  pkt_t   want;
  int     mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic int unsigned live_rate();
    if (regs.rate_code == RateAlias) return Rate192k;
    return regs.rate_code;
  endfunction

  function automatic void restart_stream();
    int unsigned r;
    r = live_rate();
    stream.block_phase   = regs.alt_pattern_mode ? 7'd0 : 7'(start_blocks[r]);
    stream.syt_phase     = 12'(start_syt_step[r]);
    stream.syt_idx       = 4'(start_syt_step[r] % 13);
    stream.last_offset   = TicksPerCycle;
    stream.block_counter = 8'd0;
  endfunction

  function automatic logic [15:0] advance_syt(input logic [12:0] cyc, input int unsigned r);
    int unsigned offset, ph, idx, total;
    if (stream.last_offset < TicksPerCycle) begin
      if (r % 2 == 0) begin
        offset = stream.last_offset + stream.syt_phase;
      end else begin
        ph = stream.syt_phase;
        idx = ph % SytCycleLen;
        offset = stream.last_offset + SytStep441;
        // extra tick on every fourth step of a 13-step group and on the last step
        if ((idx != 0 && idx % 4 == 0) || ph == SytPhaseLast) offset++;
        ph = (ph + 1 >= SytPhaseLen) ? 0 : ph + 1;
        stream.syt_phase = ph[11:0];
        stream.syt_idx   = 4'(ph % SytCycleLen);
      end
    end else begin
      offset = stream.last_offset - TicksPerCycle;
    end
    stream.last_offset = offset[12:0];
    if (stream.last_offset >= TicksPerCycle) return SytNoInfo;
    total = stream.last_offset + regs.present_delay;
    offset = ((cyc + total / TicksPerCycle) << 12) + total % TicksPerCycle;
    return offset[15:0];
  endfunction

  function automatic int unsigned advance_blocks(input int unsigned r);
    int unsigned ph, n;
    ph = stream.block_phase;
    if (r % 2 == 0) begin
      // 96k keeps the stored count even in alternate mode
      if (!regs.alt_pattern_mode || r == Rate96k) return ph;
      if (ph >= 16) ph = 0;
      n = (ph > 7) ? 5 : 7;
      ph = (ph + 1 >= 16) ? 0 : ph + 1;
      stream.block_phase = ph[6:0];
      return n;
    end
    if (r == Rate441k) n = 5 + ((ph % 2) ^ ((ph == 0 || ph >= 40) ? 1 : 0));
    else n = 11 * (r / 2) + ((ph == 0) ? 1 : 0);
    ph = (ph + 1 >= (80 >> (r / 2))) ? 0 : ph + 1;
    stream.block_phase = ph[6:0];
    return n;
  endfunction

  function automatic pkt_t predict_packet(input logic [12:0] cyc);
    int unsigned r, blocks, bytes;
    pkt_t p;
    r = live_rate();
    p.syt = advance_syt(cyc, r);
    if (!regs.blocking_mode) blocks = advance_blocks(r);
    else if (p.syt != SytNoInfo) blocks = syt_span_tab[r];
    else blocks = 0;
    if (blocks > MaxBlocks) blocks = MaxBlocks;
    bytes = 8 + blocks * 4 * regs.block_quadlets;
    p.pkt_blocks        = blocks[5:0];
    p.block_count_field = stream.block_counter;
    p.header_word0 = {2'b00, (regs.alt_pattern_mode ? 6'd0 : regs.source_node),
                      regs.block_quadlets, 8'd0, stream.block_counter};
    p.header_word1 = {CipFmtAm824, 5'd0, 3'(r), (regs.alt_pattern_mode ? 16'd0 : p.syt)};
    p.payload_bytes = bytes[14:0];
    stream.block_counter = stream.block_counter + blocks[7:0];
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] expected,
                                      input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = CfgReset;
      restart_stream();
      pending_packets.delete();
      waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRateCode:      regs.rate_code        = cfg_data_i[2:0];
          CfgBlockingMode:  regs.blocking_mode    = cfg_data_i[0];
          CfgAltPattern:    regs.alt_pattern_mode = cfg_data_i[0];
          CfgSourceNode:    regs.source_node      = cfg_data_i[5:0];
          CfgBlockQuadlets: regs.block_quadlets   = cfg_data_i[7:0];
          CfgPresentDelay:  regs.present_delay    = cfg_data_i[14:0];
          default: ;
        endcase
      end
      // results before inputs so a word cannot match a prediction made at the same edge
      if (out_valid_i && out_ready_i) begin
        if (pending_packets.size() == 0) begin
          $error("result word with no prediction waiting: syt 0x%0h", syt_i);
          mismatches++;
        end else begin
          want = pending_packets.pop_front();
          check_field("pkt_blocks", want.pkt_blocks, pkt_blocks_i);
          check_field("syt", want.syt, syt_i);
          check_field("block_count_field", want.block_count_field, block_count_field_i);
          check_field("header_word0", want.header_word0, header_word0_i);
          check_field("header_word1", want.header_word1, header_word1_i);
          check_field("payload_bytes", want.payload_bytes, payload_bytes_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == ModeStart) restart_stream();
        else pending_packets.push_back(predict_packet(cycle_i));
      end
      waiting_o <= pending_packets.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus and verdict for the cip packet timing generator
// drives the config and input channels and stalls the result channel; cptg_checker checks
// depends on cptg_pkg, cip_packet_timing_generator and cptg_checker

module testbench;
  import cptg_pkg::*;

  localparam int CycleLimit   = 150000;  // generous bound on the whole run
  localparam int SettleCycles = 8;
  localparam int NumPhases    = 9;
  localparam int PhaseWords   = 70;
  localparam int MaxGap       = 8;       // longest sender gap between words
  localparam int LongRun      = 50;      // ticks before the mid-stream rate switch

  // rate codes the package leaves unnamed
  localparam logic [2:0] Rate32k  = 3'd0;
  localparam logic [2:0] Rate48k  = 3'd2;
  // index with no register behind it, writes there must change nothing
  localparam logic [2:0] CfgSpare = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // config write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CfgRateCode;
  logic [14:0] cfg_data  = 15'd0;

  // input word channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode     = ModeTick;
  logic [12:0] cycle    = 13'd0;

  // result word channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  pkt_blocks;
  logic [15:0] syt;
  logic [7:0]  block_count_field;
  logic [31:0] header_word0;
  logic [31:0] header_word1;
  logic [14:0] payload_bytes;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int mismatches;
  int waiting;

  // register order and the bits each register keeps
  logic [2:0]  reg_index [6] = '{CfgRateCode, CfgBlockingMode, CfgAltPattern,
                                 CfgSourceNode, CfgBlockQuadlets, CfgPresentDelay};
  logic [14:0] reg_mask [6]  = '{15'h0007, 15'h0001, 15'h0001, 15'h003f, 15'h00ff, 15'h7fff};

  cip_packet_timing_generator dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .mode_i              (mode),
    .cycle_i             (cycle),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .pkt_blocks_o        (pkt_blocks),
    .syt_o               (syt),
    .block_count_field_o (block_count_field),
    .header_word0_o      (header_word0),
    .header_word1_o      (header_word1),
    .payload_bytes_o     (payload_bytes)
  );

  cptg_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .mode_i              (mode),
    .cycle_i             (cycle),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .pkt_blocks_i        (pkt_blocks),
    .syt_i               (syt),
    .block_count_field_i (block_count_field),
    .header_word0_i      (header_word0),
    .header_word1_i      (header_word1),
    .payload_bytes_i     (payload_bytes),
    .mismatches_o        (mismatches),
    .waiting_o           (waiting)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver side: random stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: a hung handshake or a lost result word ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // one input word, after an optional random gap; returns at the accepting edge
  task automatic send_word(input logic m, input logic [12:0] c);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    cycle    <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // a run of ticks with consecutive cycle numbers, as on a real bus
  task automatic run_ticks(input logic [12:0] c, input int n);
    repeat (n) begin
      send_word(ModeTick, c);
      c = c + 13'd1;
    end
  endtask

  // sender holds off until every predicted result word has come back
  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // idle block: nothing pending and a start word has had time to land
  task automatic settle();
    wait_empty();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // writes all six registers; bits above a register's width carry junk half the time
  task automatic write_settings(input cfg_t s, input bit spare);
    logic [14:0] field [6];
    int i;
    field[0] = 15'(s.rate_code);
    field[1] = 15'(s.blocking_mode);
    field[2] = 15'(s.alt_pattern_mode);
    field[3] = 15'(s.source_node);
    field[4] = 15'(s.block_quadlets);
    field[5] = 15'(s.present_delay);
    for (i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= field[i] | ($urandom_range(0, 1) ? 15'($urandom) & ~reg_mask[i] : 15'd0);
      do @(posedge clk); while (!cfg_ready);
    end
    if (spare) begin
      cfg_index <= CfgSpare;
      cfg_data  <= 15'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // first phase all lows, second all highs, then each rate code with random fields
  function automatic cfg_t phase_settings(input int ph);
    cfg_t s;
    s.rate_code        = 3'(ph - 1);
    s.blocking_mode    = 1'($urandom_range(0, 1));
    s.alt_pattern_mode = 1'($urandom_range(0, 1));
    s.source_node      = 6'($urandom);
    s.block_quadlets   = 8'($urandom);
    s.present_delay    = 15'($urandom);
    if (ph == 0) s = '{Rate32k, 1'b0, 1'b0, 6'd0, 8'd0, 15'd0};
    if (ph == 1) s = '{RateAlias, 1'b1, 1'b1, 6'd63, 8'd255, 15'd32767};
    return s;
  endfunction

  initial begin
    cfg_t        s;
    logic [12:0] c;
    int          ph, count, run, pick;
    bit          held;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ticks straight out of reset run on the reset stream state at 48k,
    // with the cycle number at both ends of its range
    send_word(ModeTick, 13'd0);
    send_word(ModeTick, 13'd8191);
    send_word(ModeTick, 13'd1);

    // defaults rewritten, plus a write to the unused index
    settle();
    write_settings(CfgReset, 1'b1);
    send_word(ModeStart, 13'd8191);
    run_ticks(13'd2, 2);

    // blocking at 48k: the fourth tick lands past the cycle, giving an empty packet
    settle();
    s = CfgReset;
    s.blocking_mode = 1'b1;
    s.source_node   = 6'd63;
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'd0);
    run_ticks(13'd100, 4);

    // alternate 7/5 pattern at 48k, header node and syt zeroed
    settle();
    s = CfgReset;
    s.alt_pattern_mode = 1'b1;
    s.source_node      = 6'd63;
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'd0);
    run_ticks(13'd200, 3);

    // alternate mode at 96k keeps the stored block count
    settle();
    s.rate_code = Rate96k;
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'd4095);
    run_ticks(13'd300, 2);

    // rate code seven aliases to 192k, widest quadlets and delay, cycle wraps
    settle();
    s = '{RateAlias, 1'b0, 1'b0, 6'd63, 8'd255, 15'd32767};
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'd8191);
    run_ticks(13'd8190, 3);

    // 44.1k with zero quadlets and zero delay
    settle();
    s = '{Rate441k, 1'b0, 1'b0, 6'd0, 8'd0, 15'd0};
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'd0);
    run_ticks(13'd7, 2);

    // long 44.1k run, then a switch to 48k with no start: the stale block phase
    // exceeds 32 and saturates, and the stale syt phase is used as the step
    send_idle_pct = 45;
    settle();
    s = CfgReset;
    s.rate_code = Rate441k;
    write_settings(s, 1'b0);
    send_word(ModeStart, 13'($urandom));
    run_ticks(13'($urandom), LongRun);
    settle();
    s.rate_code = Rate48k;
    write_settings(s, 1'b0);
    run_ticks(13'($urandom), 6);

    // random phases: mostly start-then-run streams, some stray ticks and starts
    for (ph = 0; ph < NumPhases; ph++) begin
      settle();
      write_settings(phase_settings(ph), 1'b0);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      count = 0;
      held  = 1'b0;
      // now and then the stream carries on with state left from the last setting
      if ($urandom_range(0, 3) != 0) begin
        send_word(ModeStart, 13'($urandom));
        count++;
      end
      while (count < PhaseWords) begin
        // halfway through, drain the block completely before going on
        if (!held && count >= PhaseWords / 2) begin
          wait_empty();
          held = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          c   = 13'($urandom);
          run = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) begin
            send_word(ModeStart, c);
            count++;
          end
          run_ticks(c, run);
          count += run;
        end else if (pick < 93) begin
          send_word(ModeTick, 13'($urandom));
          count++;
        end else begin
          send_word(ModeStart, 13'($urandom));
          count++;
        end
      end
    end

    // all words in, wait for the last result word and a little more
    settle();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
